@@ sv/omm_pkg.sv @@
// shared types and constants of the ordered multimap index unit
`default_nettype none
package omm_pkg;

  localparam int DEF_MAX_RECORDS = 1024;
  localparam int DEF_KEY_BITS    = 32;

  localparam int MODE_W   = 3;
  localparam int ID_W     = 10;
  localparam int FKEY_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 11;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 48;

  localparam logic [COUNT_W-1:0] COUNT_SAT = 11'd2047;

  localparam logic [MODE_W-1:0] MODE_SET       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DELETE    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GET       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CNT_EQUAL = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CNT_RANGE = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CNT_FROM  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CNT_TO    = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_SET   = 3'd0,
    OP_DEL   = 3'd1,
    OP_GET   = 3'd2,
    OP_COUNT = 3'd3,
    OP_NONE  = 3'd4,
    OP_BADID = 3'd5
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
  } cmd_ctl_t;

endpackage
`default_nettype wire

@@ sv/ordered_multimap_index_unit.sv @@
// top level of the ordered multimap index unit
`default_nettype none
// Secondary index that maps record ids to signed keys, kept as a key-sorted
// list of (key, id) pairs plus a per-id position table. Each input beat is one
// command (set, delete, get, or a count of keys equal to a value, inside a
// range, at least or at most a value) and yields exactly one result beat.
// After reset the unit runs a clearing pass over the per-id presence and key
// tables, and the sequencer takes no command during it. Timing is set by the
// sorted table: a count takes two binary searches; a delete shifts each sorted
// entry after the removed one down by one place; a set shifts entries out and
// in as needed around one binary search; a get only reads the per-id tables.
// A two-entry command queue sits in front of the sequencer and the result sits
// in an output register, so the input keeps taking beats while a result waits,
// until the queue is full.
module ordered_multimap_index_unit import omm_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  // mode[2:0], record_id[12:3], key_value[44:13], upper_bound[76:45], zero fill
  input  wire logic [IN_W-1:0]  s_tdata,
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  // status[1:0], match_count[12:2], stored_key[44:13], zero fill
  output      logic [OUT_W-1:0] m_tdata
);

  // command handoff between front and back
  logic                c_valid;
  logic                c_ready;
  cmd_ctl_t            c_ctl;
  logic [KEY_BITS-1:0] c_lo;
  logic [KEY_BITS-1:0] c_hi;

  // decode, id range check and bound selection
  omm_front #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_ctl    (c_ctl),
    .c_lo     (c_lo),
    .c_hi     (c_hi)
  );

  // table memories, shift and search sequencer, result register
  omm_back #(
    .MAX_RECORDS (MAX_RECORDS),
    .KEY_BITS    (KEY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_ctl    (c_ctl),
    .c_lo     (c_lo),
    .c_hi     (c_hi),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

@@ sv/omm_front.sv @@
// front end: accepts beats, classifies them and queues commands
`default_nettype none
module omm_front import omm_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output      logic                s_tready,
  input  wire logic [IN_W-1:0]     s_tdata,
  output      logic                c_valid,
  input  wire logic                c_ready,
  output      cmd_ctl_t            c_ctl,
  output      logic [KEY_BITS-1:0] c_lo,
  output      logic [KEY_BITS-1:0] c_hi
);

  localparam logic [31:0] MAX_W = 32'(MAX_RECORDS);

  logic [MODE_W-1:0]   mode;
  logic [ID_W-1:0]     rid;
  logic [FKEY_W-1:0]   raw_k;
  logic [FKEY_W-1:0]   raw_u;
  logic [KEY_BITS-1:0] k;
  logic [KEY_BITS-1:0] u;
  logic [KEY_BITS-1:0] kmin;
  logic [KEY_BITS-1:0] kmax;
  logic                in_range;
  cmd_ctl_t            ctl;
  logic [KEY_BITS-1:0] lo;
  logic [KEY_BITS-1:0] hi;

  assign mode  = s_tdata[2:0];
  assign rid   = s_tdata[12:3];
  assign raw_k = s_tdata[44:13];
  assign raw_u = s_tdata[76:45];

  generate
    if (KEY_BITS > FKEY_W) begin : g_wide
      assign k    = {{(KEY_BITS-FKEY_W){raw_k[FKEY_W-1]}}, raw_k};
      assign u    = {{(KEY_BITS-FKEY_W){raw_u[FKEY_W-1]}}, raw_u};
      assign kmin = {1'b1, {(KEY_BITS-1){1'b0}}};
      assign kmax = {1'b0, {(KEY_BITS-1){1'b1}}};
    end else begin : g_narrow
      localparam logic [FKEY_W-1:0] RAW_MIN = 32'h8000_0000;
      localparam logic [FKEY_W-1:0] RAW_MAX = 32'h7fff_ffff;
      assign k    = raw_k[KEY_BITS-1:0];
      assign u    = raw_u[KEY_BITS-1:0];
      assign kmin = RAW_MIN[KEY_BITS-1:0];
      assign kmax = RAW_MAX[KEY_BITS-1:0];
    end
  endgenerate

  assign in_range = 32'(rid) < MAX_W;

  always_comb begin
    ctl.id = rid;
    ctl.op = OP_NONE;
    lo     = k;
    hi     = k;
    case (mode)
      MODE_SET:       ctl.op = in_range ? OP_SET : OP_BADID;
      MODE_DELETE:    ctl.op = in_range ? OP_DEL : OP_BADID;
      MODE_GET:       ctl.op = in_range ? OP_GET : OP_BADID;
      MODE_CNT_EQUAL: ctl.op = OP_COUNT;
      MODE_CNT_RANGE: begin
        hi     = u;
        ctl.op = ($signed(k) > $signed(u)) ? OP_NONE : OP_COUNT;
      end
      MODE_CNT_FROM: begin
        hi     = kmax;
        ctl.op = ($signed(k) > $signed(kmax)) ? OP_NONE : OP_COUNT;
      end
      MODE_CNT_TO: begin
        lo     = kmin;
        ctl.op = ($signed(kmin) > $signed(k)) ? OP_NONE : OP_COUNT;
      end
      default:        ctl.op = OP_NONE;
    endcase
  end

  // two-entry command queue
  cmd_ctl_t            q_ctl [2];
  logic [KEY_BITS-1:0] q_lo  [2];
  logic [KEY_BITS-1:0] q_hi  [2];
  logic                wr_ptr;
  logic                rd_ptr;
  logic [1:0]          fill;
  logic                push;
  logic                pop;

  assign s_tready = fill != 2'd2;
  assign push     = s_tvalid && s_tready;
  assign c_valid  = fill != 2'd0;
  assign pop      = c_valid && c_ready;
  assign c_ctl    = q_ctl[rd_ptr];
  assign c_lo     = q_lo[rd_ptr];
  assign c_hi     = q_hi[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctl[wr_ptr] <= ctl;
      q_lo[wr_ptr]  <= lo;
      q_hi[wr_ptr]  <= hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) fill <= fill + 2'd1;
      else if (pop && !push) fill <= fill - 2'd1;
    end
  end

endmodule
`default_nettype wire

@@ sv/omm_back.sv @@
// back end: sorted table memories and the sequencer that updates and searches them
`default_nettype none
module omm_back import omm_pkg::*; #(
  parameter int MAX_RECORDS = DEF_MAX_RECORDS,
  parameter int KEY_BITS    = DEF_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                c_valid,
  output      logic                c_ready,
  input  wire cmd_ctl_t            c_ctl,
  input  wire logic [KEY_BITS-1:0] c_lo,
  input  wire logic [KEY_BITS-1:0] c_hi,
  output      logic                m_tvalid,
  input  wire logic                m_tready,
  output      logic [OUT_W-1:0]    m_tdata
);

  localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST_IDX = CW'(MAX_RECORDS - 1);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b000_0000_0001,
    S_IDLE   = 11'b000_0000_0010,
    S_LOOK   = 11'b000_0000_0100,
    S_RM_RD  = 11'b000_0000_1000,
    S_RM_WR  = 11'b000_0001_0000,
    S_BS_RD  = 11'b000_0010_0000,
    S_BS_CMP = 11'b000_0100_0000,
    S_IN_RD  = 11'b000_1000_0000,
    S_IN_WR  = 11'b001_0000_0000,
    S_IN_PUT = 11'b010_0000_0000,
    S_DONE   = 11'b100_0000_0000
  } state_t;

  // memories
  logic [KEY_BITS-1:0] sorted_keys [MAX_RECORDS];
  logic [ID_W-1:0]     sorted_ids  [MAX_RECORDS];
  logic [AW-1:0]       id_position [MAX_RECORDS];
  logic                id_present  [MAX_RECORDS];
  logic [KEY_BITS-1:0] id_key      [MAX_RECORDS];

  state_t              state;
  state_t              state_next;
  op_t                 op;
  logic [AW-1:0]       id_idx;
  logic [ID_W-1:0]     id_r;
  logic [KEY_BITS-1:0] key_r;
  logic [KEY_BITS-1:0] hi_r;
  logic [KEY_BITS-1:0] srch_t;
  logic                srch_le;
  logic                phase;
  logic                ins_after;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       lo_b;
  logic [CW-1:0]       hi_b;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       ins_pos;
  logic [CW-1:0]       first_pos;
  logic [CW-1:0]       clr_idx;
  logic [STATUS_W-1:0] res_status;
  logic [COUNT_W-1:0]  res_count;
  logic [FKEY_W-1:0]   res_key;

  // registered memory read data
  logic [KEY_BITS-1:0] sk_q;
  logic [ID_W-1:0]     sid_q;
  logic                present_q;
  logic [KEY_BITS-1:0] idkey_q;
  logic [AW-1:0]       pos_q;

  // memory ports
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       id_rd_addr;
  logic                s_we;
  logic [AW-1:0]       s_wa;
  logic [KEY_BITS-1:0] s_wk;
  logic [ID_W-1:0]     s_wi;
  logic                p_we;
  logic [AW-1:0]       p_wa;
  logic [AW-1:0]       p_wd;
  logic                i_we;
  logic [AW-1:0]       i_wa;
  logic                i_wp;
  logic [KEY_BITS-1:0] i_wk;

  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid;
  logic                go_right;
  logic [CW-1:0]       diff;
  logic [COUNT_W-1:0]  diff_sat;
  logic [FKEY_W-1:0]   key_out;
  logic                out_free;

  generate
    if (KEY_BITS >= FKEY_W) begin : g_kout_trunc
      assign key_out = idkey_q[FKEY_W-1:0];
    end else begin : g_kout_ext
      assign key_out = {{(FKEY_W-KEY_BITS){idkey_q[KEY_BITS-1]}}, idkey_q};
    end
  endgenerate

  assign mid_sum  = {1'b0, lo_b} + {1'b0, hi_b};
  assign mid      = mid_sum[CW:1];
  assign go_right = srch_le ? ($signed(sk_q) <= $signed(srch_t))
                            : ($signed(sk_q) <  $signed(srch_t));
  assign diff     = lo_b - first_pos;
  assign diff_sat = (32'(diff) > 32'(COUNT_SAT)) ? COUNT_SAT : COUNT_W'(diff);
  assign out_free = !m_tvalid || m_tready;
  assign c_ready  = state == S_IDLE;

  always_ff @(posedge clk) begin
    sk_q      <= sorted_keys[rd_addr];
    sid_q     <= sorted_ids[rd_addr];
    present_q <= id_present[id_rd_addr];
    idkey_q   <= id_key[id_rd_addr];
    pos_q     <= id_position[id_rd_addr];
    if (s_we) begin
      sorted_keys[s_wa] <= s_wk;
      sorted_ids[s_wa]  <= s_wi;
    end
    if (p_we) id_position[p_wa] <= p_wd;
    if (i_we) begin
      id_present[i_wa] <= i_wp;
      id_key[i_wa]     <= i_wk;
    end
  end

  // memory port control
  always_comb begin
    rd_addr    = mid[AW-1:0];
    id_rd_addr = (state == S_IDLE) ? AW'(c_ctl.id) : id_idx;
    s_we       = 1'b0;
    s_wa       = idx[AW-1:0];
    s_wk       = sk_q;
    s_wi       = sid_q;
    p_we       = 1'b0;
    p_wa       = AW'(sid_q);
    p_wd       = idx[AW-1:0];
    i_we       = 1'b0;
    i_wa       = id_idx;
    i_wp       = 1'b0;
    i_wk       = key_r;
    case (state)
      S_CLEAR: begin
        i_we = 1'b1;
        i_wa = clr_idx[AW-1:0];
        i_wk = '0;
      end
      S_LOOK: begin
        if (op == OP_SET) begin
          i_we = 1'b1;
          i_wp = 1'b1;
        end else if (op == OP_DEL && present_q) begin
          i_we = 1'b1;
          i_wk = idkey_q;
        end
      end
      S_RM_RD:  rd_addr = AW'(idx + CW'(1));
      S_IN_RD:  rd_addr = AW'(idx - CW'(1));
      S_RM_WR, S_IN_WR: begin
        s_we = 1'b1;
        p_we = 1'b1;
      end
      S_IN_PUT: begin
        s_we = 1'b1;
        s_wa = ins_pos[AW-1:0];
        s_wk = key_r;
        s_wi = id_r;
        p_we = 1'b1;
        p_wa = id_idx;
        p_wd = ins_pos[AW-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (clr_idx == LAST_IDX) state_next = S_IDLE;
      S_IDLE: begin
        if (c_valid) begin
          case (c_ctl.op)
            OP_SET, OP_DEL, OP_GET: state_next = S_LOOK;
            OP_COUNT:               state_next = S_BS_RD;
            default:                state_next = S_DONE;
          endcase
        end
      end
      S_LOOK: begin
        case (op)
          OP_SET: begin
            if (!present_q) state_next = S_BS_RD;
            else if (idkey_q == key_r) state_next = S_DONE;
            else state_next = S_RM_RD;
          end
          OP_DEL:  state_next = present_q ? S_RM_RD : S_DONE;
          default: state_next = S_DONE;
        endcase
      end
      S_RM_RD: begin
        if (idx + CW'(1) < cnt) state_next = S_RM_WR;
        else state_next = ins_after ? S_BS_RD : S_DONE;
      end
      S_RM_WR:  state_next = S_RM_RD;
      S_BS_RD: begin
        if (lo_b < hi_b) state_next = S_BS_CMP;
        else if (op == OP_SET) state_next = S_IN_RD;
        else if (phase) state_next = S_DONE;
      end
      S_BS_CMP: state_next = S_BS_RD;
      S_IN_RD:  state_next = (idx > ins_pos) ? S_IN_WR : S_IN_PUT;
      S_IN_WR:  state_next = S_IN_RD;
      S_IN_PUT: state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_idx  <= '0;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      // result register: load a finished result, else drop a taken beat
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {3'b000, res_key, res_count, res_status};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_idx <= clr_idx + CW'(1);
        S_IDLE: begin
          if (c_valid) begin
            op         <= c_ctl.op;
            id_r       <= c_ctl.id;
            id_idx     <= AW'(c_ctl.id);
            key_r      <= c_lo;
            hi_r       <= c_hi;
            res_status <= (c_ctl.op == OP_BADID) ? ST_RANGE : ST_OK;
            res_count  <= '0;
            res_key    <= '0;
            srch_t     <= c_lo;
            srch_le    <= 1'b0;
            phase      <= 1'b0;
            ins_after  <= 1'b0;
            lo_b       <= '0;
            hi_b       <= cnt;
          end
        end
        S_LOOK: begin
          idx       <= CW'(pos_q);
          srch_t    <= key_r;
          srch_le   <= 1'b1;
          ins_after <= 1'b1;
          if (op == OP_GET) begin
            res_status <= present_q ? ST_OK : ST_ABSENT;
            res_key    <= key_out;
          end else if (op == OP_DEL && !present_q) begin
            res_status <= ST_ABSENT;
          end
          if (op == OP_DEL) ins_after <= 1'b0;
        end
        S_RM_RD: begin
          if (!(idx + CW'(1) < cnt)) begin
            cnt  <= cnt - CW'(1);
            lo_b <= '0;
            hi_b <= cnt - CW'(1);
          end
        end
        S_RM_WR: idx <= idx + CW'(1);
        S_BS_RD: begin
          if (!(lo_b < hi_b)) begin
            if (op == OP_SET) begin
              ins_pos <= lo_b;
              idx     <= cnt;
            end else if (!phase) begin
              // lower bound found, now look for the end of the range
              first_pos <= lo_b;
              phase     <= 1'b1;
              srch_t    <= hi_r;
              srch_le   <= 1'b1;
              hi_b      <= cnt;
            end else begin
              res_count <= diff_sat;
            end
          end
        end
        S_BS_CMP: begin
          if (go_right) lo_b <= mid + CW'(1);
          else hi_b <= mid;
        end
        S_IN_WR:  idx <= idx - CW'(1);
        S_IN_PUT: cnt <= cnt + CW'(1);
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire
